### rtl/b2b_pkg.sv
// Shared types, constants and helper functions for the BLAKE2b hash core.
`timescale 1ns / 1ps

package b2b_pkg;

    typedef logic [63:0] word_t;

    localparam word_t IV0 = 64'h6a09e667f3bcc908;
    localparam word_t IV1 = 64'hbb67ae8584caa73b;
    localparam word_t IV2 = 64'h3c6ef372fe94f82b;
    localparam word_t IV3 = 64'ha54ff53a5f1d36f1;
    localparam word_t IV4 = 64'h510e527fade682d1;
    localparam word_t IV5 = 64'h9b05688c2b3e6c1f;
    localparam word_t IV6 = 64'h1f83d9abfb41bd6b;
    localparam word_t IV7 = 64'h5be0cd19137e2179;

    localparam word_t PARAM_BASE = 64'h0000000001010000;
    localparam int unsigned ROUNDS = 12;

    // One compression job handed from the front end to the back end.
    typedef struct packed {
        logic [15:0][63:0] msg;
        logic [63:0]       count;
        logic              last;
        logic [6:0]        init_len;
    } job_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = IV0;
            3'd1: r = IV1;
            3'd2: r = IV2;
            3'd3: r = IV3;
            3'd4: r = IV4;
            3'd5: r = IV5;
            3'd6: r = IV6;
            default: r = IV7;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] eff_len(input logic [6:0] l);
        logic [6:0] r;
        if (l == 7'd0) r = 7'd1;
        else if (l > 7'd64) r = 7'd64;
        else r = l;
        return r;
    endfunction

    // Message word index for sigma row r and slot s.
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            default: row = 64'h0dc3e9bf5167482a;
        endcase
        return row[s*4 +: 4];
    endfunction

    function automatic word_t rotr(input word_t v, input int unsigned s);
        return (v >> s) | (v << (64 - s));
    endfunction

endpackage

### rtl/b2b_front.sv
// Front end: collects sixteen message words into a block and queues a compression job.
`timescale 1ns / 1ps

module b2b_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [63:0]       message_word,
    input  logic              final_block,
    input  logic [7:0]        final_bytes,
    input  logic [6:0]        cur_len,
    output logic              job_valid,
    output b2b_pkg::job_t     job,
    input  logic              job_take
);
    import b2b_pkg::*;

    logic [15:0][63:0] buf_reg;
    logic [3:0]        pos_reg;
    logic              open_reg;
    logic [63:0]       count_reg;
    logic [6:0]        len_reg;
    logic              job_valid_reg;
    job_t              job_reg;
    logic              acc;
    logic [7:0]        fb;
    logic [15:0][63:0] blk;
    logic [6:0]        len_now;

    assign full      = job_valid_reg && !job_take && (pos_reg == 4'd15);
    assign acc       = push && !full;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign len_now   = open_reg ? len_reg : eff_len(cur_len);
    assign fb        = (final_bytes > 8'd128) ? 8'd128 : final_bytes;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk[i] = (i == 15) ? message_word : buf_reg[i];
            if (final_block)
            begin
                for (int b = 0; b < 8; b++)
                begin
                    if (8'(i * 8 + b) >= fb)
                    begin
                        blk[i][b*8 +: 8] = 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            buf_reg[pos_reg] <= message_word;
        end
        if (acc && pos_reg == 4'd15)
        begin
            job_reg.msg      <= blk;
            job_reg.last     <= final_block;
            job_reg.init_len <= len_now;
            job_reg.count    <= (open_reg ? count_reg : 64'd0)
                                + (final_block ? {56'd0, fb} : 64'd128);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            open_reg      <= 1'b0;
            count_reg     <= 64'd0;
            len_reg       <= 7'd64;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc && pos_reg == 4'd15)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
            if (acc)
            begin
                pos_reg <= pos_reg + 4'd1;
                if (!open_reg)
                begin
                    open_reg  <= 1'b1;
                    len_reg   <= eff_len(cur_len);
                    count_reg <= 64'd0;
                end
                if (pos_reg == 4'd15)
                begin
                    if (final_block)
                    begin
                        open_reg  <= 1'b0;
                        count_reg <= 64'd0;
                    end
                    else
                    begin
                        count_reg <= (open_reg ? count_reg : 64'd0) + 64'd128;
                    end
                end
            end
        end
    end

endmodule

### rtl/b2b_core.sv
// Back end: iterated compression, one column or diagonal half-step of four G mixes a cycle.
`timescale 1ns / 1ps

module b2b_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  b2b_pkg::job_t job,
    output logic          job_take,
    output logic          done,
    output logic [511:0]  hash,
    input  logic          out_free
);
    import b2b_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t             state_reg;
    logic [15:0][63:0]  msg_reg;
    logic [15:0][63:0]  v_reg;
    logic [7:0][63:0]   h_reg;
    logic [3:0]         round_reg;
    logic [1:0]         phase_reg;
    logic               last_reg;
    logic               open_reg;
    logic [15:0][63:0]  v_next;
    logic [7:0][63:0]   h_start;
    logic [3:0]         srow;

    assign srow     = (round_reg >= 4'd10) ? round_reg - 4'd10 : round_reg;
    assign job_take = job_valid && (state_reg == S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign hash     = h_reg;

    // Chain value at job start: fresh IV with parameter word at message start, else the running chain value.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_start[i] = iv_word(3'(i));
        end
        h_start[0] = IV0 ^ PARAM_BASE ^ {57'd0, job.init_len};
        if (open_reg)
        begin
            h_start = h_reg;
        end
    end

    // Each cycle covers one half of G for four lanes: phase 0/1 columns, 2/3 diagonals.
    always_comb
    begin
        logic [3:0] a, b, c, d;
        logic [63:0] x;
        logic [3:0] slot;
        v_next = v_reg;
        for (int l = 0; l < 4; l++)
        begin
            a = 4'(l);
            if (phase_reg[1])
            begin
                b = 4'(4 + ((l + 1) % 4));
                c = 4'(8 + ((l + 2) % 4));
                d = 4'(12 + ((l + 3) % 4));
                slot = 4'(8 + 2 * l);
            end
            else
            begin
                b = 4'(4 + l);
                c = 4'(8 + l);
                d = 4'(12 + l);
                slot = 4'(2 * l);
            end
            slot = slot + {3'd0, phase_reg[0]};
            x = msg_reg[sigma(srow, slot)];
            v_next[a] = v_reg[a] + v_reg[b] + x;
            v_next[d] = rotr(v_reg[d] ^ v_next[a], phase_reg[0] ? 16 : 32);
            v_next[c] = v_reg[c] + v_next[d];
            v_next[b] = rotr(v_reg[b] ^ v_next[c], phase_reg[0] ? 63 : 24);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            msg_reg  <= job.msg;
            last_reg <= job.last;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_start[i];
                h_reg[i] <= h_start[i];
            end
            v_reg[8]  <= IV0;
            v_reg[9]  <= IV1;
            v_reg[10] <= IV2;
            v_reg[11] <= IV3;
            v_reg[12] <= IV4 ^ job.count;
            v_reg[13] <= IV5;
            v_reg[14] <= job.last ? ~IV6 : IV6;
            v_reg[15] <= IV7;
        end
        else if (state_reg == S_RUN)
        begin
            v_reg <= v_next;
            if (round_reg == 4'(ROUNDS - 1) && phase_reg == 2'd3)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] ^ v_next[i] ^ v_next[i + 8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= 4'd0;
            phase_reg <= 2'd0;
            open_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        state_reg <= S_RUN;
                        round_reg <= 4'd0;
                        phase_reg <= 2'd0;
                        open_reg  <= 1'b1;
                    end
                end
                S_RUN:
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        round_reg <= round_reg + 4'd1;
                        if (round_reg == 4'(ROUNDS - 1))
                        begin
                            state_reg <= last_reg ? S_DONE : S_IDLE;
                            if (last_reg)
                            begin
                                open_reg <= 1'b0;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/b2b_out.sv
// Output stage: splits the digest into trimmed little-endian words.
`timescale 1ns / 1ps

module b2b_out
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         done,
    input  logic [511:0] hash,
    input  logic [6:0]   cur_len,
    output logic         out_free,
    output logic         empty,
    input  logic         pop,
    output logic [63:0]  digest_word,
    output logic [3:0]   valid_bytes,
    output logic         last_word
);
    import b2b_pkg::*;

    logic [7:0][63:0] dig_reg;
    logic             busy_reg;
    logic [2:0]       idx_reg;
    logic [6:0]       len;
    logic [6:0]       rem;
    logic [2:0]       nlast;

    assign len      = eff_len(cur_len);
    assign nlast    = 3'((len - 7'd1) >> 3);
    assign rem      = len - {1'b0, idx_reg, 3'd0};
    assign out_free = !busy_reg;
    assign empty    = !busy_reg;
    assign valid_bytes = (rem >= 7'd8) ? 4'd8 : rem[3:0];
    assign last_word   = (idx_reg == nlast);

    always_comb
    begin
        digest_word = dig_reg[idx_reg];
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) >= valid_bytes)
            begin
                digest_word[b*8 +: 8] = 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && !busy_reg)
        begin
            dig_reg <= hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (!busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 3'd0;
            end
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (last_word)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/blake2b_hash_core_unit.sv
// Top level of the unkeyed BLAKE2b hash core.
// One 128-byte block is taken in 16 requests, one per cycle while full is low; its
// compression runs 12 rounds, four half-G steps per round on four lanes.
// The front end collects the next block's requests while the current block compresses.
// rst_n clears control state asynchronously; digest length resets to 64.
`timescale 1ns / 1ps

module blake2b_hash_core_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [63:0] message_word,
    input  logic        final_block,
    input  logic [7:0]  final_bytes,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic [3:0]  valid_bytes,
    output logic        last_word
);
    import b2b_pkg::*;

    logic [6:0]   len_reg;
    logic         job_valid;
    job_t         job;
    logic         job_take;
    logic         done;
    logic [511:0] hash;
    logic         out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    b2b_front u_front (
        .clk, .rst_n, .push, .full, .message_word, .final_block, .final_bytes,
        .cur_len(len_reg), .job_valid, .job, .job_take
    );

    b2b_core u_core (
        .clk, .rst_n, .job_valid, .job, .job_take, .done, .hash, .out_free
    );

    b2b_out u_out (
        .clk, .rst_n, .done, .hash, .cur_len(len_reg), .out_free, .empty, .pop,
        .digest_word, .valid_bytes, .last_word
    );

endmodule
